>>> rtl/core/fbc_pkg.sv
package fbc_pkg;

   localparam int PLANE_COUNT_DEFAULT = 6;
   localparam int COORD_BITS_DEFAULT  = 20;

   // configuration port
   localparam int REG_COUNT      = 6;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   // plane register packing: a, b, c signed Q1.10, d signed Q13.14
   localparam int COEF_BITS = 12;
   localparam int A_LSB     = 0;
   localparam int B_LSB     = 12;
   localparam int C_LSB     = 24;
   localparam int D_LSB     = 36;
   localparam int D_BITS    = 28;
   // d is scaled up to the 18 fraction bits of the products
   localparam int D_SHIFT       = 4;
   localparam int D_SCALED_BITS = D_BITS + D_SHIFT;

   localparam logic OP_POINT = 1'b0;
   localparam logic OP_BOX   = 1'b1;

   localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
   localparam logic [1:0] VERDICT_PARTIAL = 2'd1;
   localparam logic [1:0] VERDICT_INSIDE  = 2'd2;

   // running verdict handed from cell to cell
   typedef struct packed {
      logic valid;
      logic op;
      logic any_out;   // some plane has no corner on its positive side
      logic all_in;    // every plane so far has every corner on its positive side
   } fbc_flags_type;

endpackage

>>> rtl/core/fbc_cell.sv
module fbc_cell
   import fbc_pkg::*;
#(
   parameter int COORD_BITS  = COORD_BITS_DEFAULT,
   parameter int PLANE_INDEX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data,
   input  fbc_flags_type                 in_flags,
   input  logic signed [COORD_BITS-1:0]  in_x,
   input  logic signed [COORD_BITS-1:0]  in_y,
   input  logic signed [COORD_BITS-1:0]  in_z,
   input  logic [COORD_BITS-2:0]         in_half,
   input  logic [COORD_BITS-2:0]         in_up,
   output fbc_flags_type                 out_flags,
   output logic signed [COORD_BITS-1:0]  out_x,
   output logic signed [COORD_BITS-1:0]  out_y,
   output logic signed [COORD_BITS-1:0]  out_z,
   output logic [COORD_BITS-2:0]         out_half,
   output logic [COORD_BITS-2:0]         out_up
);

   localparam int PROD_BITS = COORD_BITS + 13;
   localparam int SUM_BITS  = ((PROD_BITS > D_SCALED_BITS) ? PROD_BITS : D_SCALED_BITS) + 3;
   localparam bit WRITABLE  = PLANE_INDEX < REG_COUNT;

   logic [CSR_DATA_BITS-1:0] plane_ff, plane_in;

   logic signed [COEF_BITS-1:0] coef_a, coef_b, coef_c;
   logic signed [D_BITS-1:0]    coef_d;
   logic signed [COORD_BITS:0]  y_lo, y_hi;

   // stage A: products
   fbc_flags_type                flags_a_ff;
   logic signed [COORD_BITS-1:0] x_a_ff, y_a_ff, z_a_ff;
   logic [COORD_BITS-2:0]        half_a_ff, up_a_ff;
   logic signed [PROD_BITS-1:0]  pax_ff, pcz_ff, pbl_ff, pbh_ff, pah_ff, pch_ff;
   logic signed [PROD_BITS-1:0]  pax_in, pcz_in, pbl_in, pbh_in, pah_in, pch_in;

   // stage B: corner extremes and compare
   fbc_flags_type                flags_b_ff, flags_b_in;
   logic signed [COORD_BITS-1:0] x_b_ff, y_b_ff, z_b_ff;
   logic [COORD_BITS-2:0]        half_b_ff, up_b_ff;

   logic signed [SUM_BITS-1:0]  d_scaled, base, sum_max, sum_min;
   logic signed [PROD_BITS-1:0] y_max, y_min, abs_ah, abs_ch;
   logic                        max_nonpos, min_pos;

   always_comb begin
      plane_in = plane_ff;
      if (WRITABLE && csr_we && csr_index == CSR_INDEX_BITS'(PLANE_INDEX)) begin
         plane_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else begin
         plane_ff <= plane_in;
      end
   end

   assign coef_a = signed'(plane_ff[A_LSB +: COEF_BITS]);
   assign coef_b = signed'(plane_ff[B_LSB +: COEF_BITS]);
   assign coef_c = signed'(plane_ff[C_LSB +: COEF_BITS]);
   assign coef_d = signed'(plane_ff[D_LSB +: D_BITS]);

   assign y_lo = (COORD_BITS+1)'(in_y) - signed'({2'b00, in_half});
   assign y_hi = (COORD_BITS+1)'(in_y) + signed'({2'b00, in_up});

   assign pax_in = PROD_BITS'(coef_a) * PROD_BITS'(in_x);
   assign pcz_in = PROD_BITS'(coef_c) * PROD_BITS'(in_z);
   assign pbl_in = PROD_BITS'(coef_b) * PROD_BITS'(y_lo);
   assign pbh_in = PROD_BITS'(coef_b) * PROD_BITS'(y_hi);
   assign pah_in = PROD_BITS'(coef_a) * signed'(PROD_BITS'(in_half));
   assign pch_in = PROD_BITS'(coef_c) * signed'(PROD_BITS'(in_half));

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_a_ff <= '0;
      end else begin
         flags_a_ff <= in_flags;
      end
   end

   always_ff @(posedge clock) begin
      x_a_ff    <= in_x;
      y_a_ff    <= in_y;
      z_a_ff    <= in_z;
      half_a_ff <= in_half;
      up_a_ff   <= in_up;
      pax_ff    <= pax_in;
      pcz_ff    <= pcz_in;
      pbl_ff    <= pbl_in;
      pbh_ff    <= pbh_in;
      pah_ff    <= pah_in;
      pch_ff    <= pch_in;
   end

   // x and z corners sit at +-half, so their extremes are +-|a*half| and +-|c*half|
   always_comb begin
      d_scaled = SUM_BITS'(coef_d) <<< D_SHIFT;
      base     = SUM_BITS'(pax_ff) + SUM_BITS'(pcz_ff) + d_scaled;
      y_max    = (pbl_ff > pbh_ff) ? pbl_ff : pbh_ff;
      y_min    = (pbl_ff > pbh_ff) ? pbh_ff : pbl_ff;
      abs_ah   = pah_ff[PROD_BITS-1] ? -pah_ff : pah_ff;
      abs_ch   = pch_ff[PROD_BITS-1] ? -pch_ff : pch_ff;
      sum_max  = base + SUM_BITS'(y_max) + SUM_BITS'(abs_ah) + SUM_BITS'(abs_ch);
      sum_min  = base + SUM_BITS'(y_min) - SUM_BITS'(abs_ah) - SUM_BITS'(abs_ch);

      max_nonpos = sum_max[SUM_BITS-1] || (sum_max == '0);
      min_pos    = !sum_min[SUM_BITS-1] && (sum_min != '0);

      flags_b_in         = flags_a_ff;
      flags_b_in.any_out = flags_a_ff.any_out | max_nonpos;
      flags_b_in.all_in  = flags_a_ff.all_in & min_pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_b_ff <= '0;
      end else begin
         flags_b_ff <= flags_b_in;
      end
   end

   always_ff @(posedge clock) begin
      x_b_ff    <= x_a_ff;
      y_b_ff    <= y_a_ff;
      z_b_ff    <= z_a_ff;
      half_b_ff <= half_a_ff;
      up_b_ff   <= up_a_ff;
   end

   assign out_flags = flags_b_ff;
   assign out_x     = x_b_ff;
   assign out_y     = y_b_ff;
   assign out_z     = z_b_ff;
   assign out_half  = half_b_ff;
   assign out_up    = up_b_ff;

endmodule

>>> rtl/core/frustum_box_cull.sv
// Tests a point or an axis-aligned box against PLANE_COUNT clipping planes, one
// test accepted every clock cycle; busy is always low. Each plane lives in its own
// cell of a chain, and a cell spends two register stages on a test (products, then
// the corner extremes and the sign check), so the verdict appears on rsp_verdict,
// registered once more after the last cell, with a one-cycle rsp_valid strobe,
// in order. The receiver cannot stall the block and must take every strobe.
// Verdicts: 0 outside, 1 point inside or box partly inside, 2 box wholly inside.
// Plane registers are written at csr index 0..5 (right, left, bottom, top, far,
// near) and must only be changed while no test is in flight.
module frustum_box_cull
   import fbc_pkg::*;
#(
   parameter int PLANE_COUNT = PLANE_COUNT_DEFAULT,
   parameter int COORD_BITS  = COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic signed [COORD_BITS-1:0]  req_pos_x,
   input  logic signed [COORD_BITS-1:0]  req_pos_y,
   input  logic signed [COORD_BITS-1:0]  req_pos_z,
   input  logic [COORD_BITS-2:0]         req_half_extent,
   input  logic [COORD_BITS-2:0]         req_upward_extent,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_verdict,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   localparam int LATENCY = 2 * PLANE_COUNT + 1;

   fbc_flags_type                flags_chain [PLANE_COUNT+1];
   logic signed [COORD_BITS-1:0] x_chain     [PLANE_COUNT+1];
   logic signed [COORD_BITS-1:0] y_chain     [PLANE_COUNT+1];
   logic signed [COORD_BITS-1:0] z_chain     [PLANE_COUNT+1];
   logic [COORD_BITS-2:0]        half_chain  [PLANE_COUNT+1];
   logic [COORD_BITS-2:0]        up_chain    [PLANE_COUNT+1];

   fbc_flags_type tail_flags;
   logic          accept;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_verdict_ff, rsp_verdict_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // a point is a box of zero extent
   always_comb begin
      flags_chain[0].valid   = accept;
      flags_chain[0].op      = req_operation;
      flags_chain[0].any_out = 1'b0;
      flags_chain[0].all_in  = 1'b1;
      x_chain[0]             = req_pos_x;
      y_chain[0]             = req_pos_y;
      z_chain[0]             = req_pos_z;
      half_chain[0]          = (req_operation == OP_BOX) ? req_half_extent : '0;
      up_chain[0]            = (req_operation == OP_BOX) ? req_upward_extent : '0;
   end

   for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
      fbc_cell #(
         .COORD_BITS  (COORD_BITS),
         .PLANE_INDEX (p)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .csr_we    (csr_we),
         .csr_index (csr_index),
         .csr_data  (csr_data),
         .in_flags  (flags_chain[p]),
         .in_x      (x_chain[p]),
         .in_y      (y_chain[p]),
         .in_z      (z_chain[p]),
         .in_half   (half_chain[p]),
         .in_up     (up_chain[p]),
         .out_flags (flags_chain[p+1]),
         .out_x     (x_chain[p+1]),
         .out_y     (y_chain[p+1]),
         .out_z     (z_chain[p+1]),
         .out_half  (half_chain[p+1]),
         .out_up    (up_chain[p+1])
      );
   end

   assign tail_flags = flags_chain[PLANE_COUNT];

   always_comb begin
      rsp_valid_in = tail_flags.valid;
      unique case (tail_flags.op)
         OP_POINT: begin
            rsp_verdict_in = tail_flags.all_in ? VERDICT_PARTIAL : VERDICT_OUTSIDE;
         end
         OP_BOX: begin
            if (tail_flags.any_out) begin
               rsp_verdict_in = VERDICT_OUTSIDE;
            end else if (tail_flags.all_in) begin
               rsp_verdict_in = VERDICT_INSIDE;
            end else begin
               rsp_verdict_in = VERDICT_PARTIAL;
            end
         end
         default: begin
            rsp_verdict_in = VERDICT_OUTSIDE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

`ifndef SYNTHESIS
   a_result_follows_start : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("accepted test produced no result at the expected latency");

   a_no_spurious_result : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("result strobe without a matching accepted test");

   a_inside_only_for_box : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_verdict == VERDICT_INSIDE) |-> ($past(tail_flags.op) == OP_BOX))
      else $error("wholly-inside verdict given for a point test");

   a_box_outside_matches_flags : assert property (@(posedge clock) disable iff (reset)
      (tail_flags.valid && tail_flags.op == OP_BOX)
         |=> (rsp_verdict == VERDICT_OUTSIDE) == $past(tail_flags.any_out))
      else $error("box outside verdict disagrees with plane flags");
`endif

endmodule
